// ===== sv/spi_serial_eeprom_device_top_macros.svh =====
`ifndef SPI_SERIAL_EEPROM_DEVICE_TOP_MACROS_SVH
`define SPI_SERIAL_EEPROM_DEVICE_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SEE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spi_eeprom_pkg.sv =====
`default_nettype none

package spi_eeprom_pkg;

    localparam int ADDR_BITS_DEF = 14;
    localparam int PAGE_BITS_DEF = 6;
    localparam int BUSY_W        = 16;

    localparam logic [BUSY_W-1:0] WCT_RESET = 16'd100;

    localparam logic [7:0] OP_NONE  = 8'h00;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_RDSR  = 8'h05;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA
    } t_phase;

endpackage

`default_nettype wire

// ===== sv/spi_serial_eeprom_device_top.sv =====
// Channel   Direction  Content
// s_axis    in         tdata[7:0] mosi_byte; tuser cmd (1 = tick); tlast end_of_frame
// m_axis    out        tdata[7:0] miso_byte, [8] write_in_progress, [9] write_enabled
// cfg       in         i_cfg_wdata: write_cycle_ticks on i_cfg_we
//
// One transaction is accepted per clock; the cell array has one synchronous
// port, read or written once per item; results pass the s1 and out registers.
// Synchronous active-low reset clears frame state, latch, busy count and
// pipeline valids; write_cycle_ticks returns to 100. The array is not cleared.
// A stalled output fills the result stage, then input ready drops.
`default_nettype none
`include "spi_serial_eeprom_device_top_macros.svh"

module spi_serial_eeprom_device_top
    import spi_eeprom_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] mosi_byte
    input  wire logic        i_s_axis_tuser,   // [0] cmd
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] miso_byte, [8] write_in_progress,
                                               // [9] write_enabled, [15:10] zero
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]           mem [0:DEPTH-1];
    logic [7:0]           r_rd_data;

    t_phase               r_phase, n_phase;
    logic [7:0]           r_opcode, n_opcode;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic                 r_wen, n_wen;
    logic                 r_written, n_written;
    logic [BUSY_W-1:0]    r_busy, n_busy;
    logic [BUSY_W-1:0]    r_wct;

    logic                 r_s1_valid;
    logic                 r_s1_mem, n_s1_mem;
    logic [7:0]           r_s1_byte, n_s1_byte;
    logic                 r_s1_wip;
    logic                 r_s1_we;
    logic                 r_out_valid;
    logic [15:0]          r_out_data;

    logic                 accept;
    logic                 s1_move;
    logic                 mem_we;
    logic                 mem_re;
    logic                 take;
    logic                 busy;
    logic [15:0]          addr_hi16;
    logic [15:0]          addr_lo16;
    logic [7:0]           b;

    assign b         = i_s_axis_tdata;
    assign busy      = (r_busy != '0);
    assign addr_hi16 = {b, 8'h00};
    assign addr_lo16 = {8'h00, b};
    assign s1_move   = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_addr    = r_addr;
        n_wen     = r_wen;
        n_written = r_written;
        n_busy    = r_busy;
        n_s1_mem  = 1'b0;
        n_s1_byte = 8'h00;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        take      = 1'b0;
        if (accept) begin
            if (i_s_axis_tuser) begin
                if (busy) begin
                    n_busy = r_busy - {{(BUSY_W-1){1'b0}}, 1'b1};
                end
            end else begin
                unique case (r_phase)
                    PH_OPCODE: begin
                        priority if (b == OP_RDSR) begin
                            take = 1'b1;
                        end else if (busy) begin
                            take = 1'b0;
                        end else if (b == OP_READ || b == OP_WREN) begin
                            take = 1'b1;
                        end else if (b == OP_WRITE) begin
                            take = r_wen;
                        end else begin
                            take = 1'b0;
                        end
                        n_opcode  = take ? b : OP_NONE;
                        n_written = 1'b0;
                        n_phase   = (take && (b == OP_READ || b == OP_WRITE)) ?
                                    PH_ADDR_HI : PH_DATA;
                    end
                    PH_ADDR_HI: begin
                        n_addr  = addr_hi16[ADDR_BITS-1:0];
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_addr  = r_addr | addr_lo16[ADDR_BITS-1:0];
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        priority if (r_opcode == OP_RDSR) begin
                            n_s1_byte = {6'b0, r_wen, busy};
                        end else if (r_opcode == OP_READ) begin
                            mem_re   = 1'b1;
                            n_s1_mem = 1'b1;
                            n_addr   = r_addr + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                        end else if (r_opcode == OP_WRITE) begin
                            mem_we    = 1'b1;
                            n_addr    = {r_addr[ADDR_BITS-1:PAGE_BITS],
                                         r_addr[PAGE_BITS-1:0]
                                         + {{(PAGE_BITS-1){1'b0}}, 1'b1}};
                            n_written = 1'b1;
                        end else begin
                            n_s1_byte = 8'h00;
                        end
                    end
                    default: begin
                        n_phase = PH_OPCODE;
                    end
                endcase
                if (i_s_axis_tlast) begin
                    priority if (n_opcode == OP_WREN && n_phase == PH_DATA) begin
                        n_wen = 1'b1;
                    end else if (n_opcode == OP_WRITE && n_written) begin
                        n_wen  = 1'b0;
                        n_busy = r_wct;
                    end else begin
                        n_wen = r_wen;
                    end
                    n_phase   = PH_OPCODE;
                    n_written = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= b;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_opcode    <= OP_NONE;
            r_addr      <= '0;
            r_wen       <= 1'b0;
            r_written   <= 1'b0;
            r_busy      <= '0;
            r_wct       <= WCT_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_addr    <= n_addr;
            r_wen     <= n_wen;
            r_written <= n_written;
            r_busy    <= n_busy;
            if (i_cfg_we) begin
                r_wct <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mem  <= n_s1_mem;
            r_s1_byte <= n_s1_byte;
            r_s1_wip  <= (n_busy != '0);
            r_s1_we   <= n_wen;
        end
        if (s1_move && r_s1_valid) begin
            r_out_data <= {6'b0, r_s1_we, r_s1_wip, r_s1_mem ? r_rd_data : r_s1_byte};
        end
    end

    `SEE_ASSERT_SAME(a_no_write_while_busy, r_busy != '0, !mem_we, "array written while busy")
    `SEE_ASSERT_SAME(a_opcode_known,
        1'b1,
        r_opcode == OP_NONE || r_opcode == OP_READ || r_opcode == OP_WRITE ||
        r_opcode == OP_WREN || r_opcode == OP_RDSR,
        "frame opcode register holds an unknown code")
    `SEE_ASSERT_NEXT(a_wen_clear_after_write,
        accept && !i_s_axis_tuser && i_s_axis_tlast && r_opcode == OP_WRITE &&
        (r_written || mem_we),
        !r_wen,
        "write enable still set after a write frame")

endmodule

`default_nettype wire
